/* sv/two_set_membership_engine_top_assert.svh */
// Assertion macros for the two-set membership engine.
// Included by modules that check their own control logic.
`ifndef TWO_SET_MEMBERSHIP_ENGINE_TOP_ASSERT_SVH
`define TWO_SET_MEMBERSHIP_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TSM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TSM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TSM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TSM_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

/* sv/tsm_pkg.sv */
// Shared types and operation codes for the two-set membership engine.
// No dependencies.
`default_nettype none
package tsm_pkg;
    typedef enum logic [2:0] {
        FN_ADD = 3'd0, FN_REMOVE = 3'd1, FN_CONTAINS = 3'd2, FN_SIZE = 3'd3,
        FN_INTERSECT = 3'd4, FN_UNION = 3'd5, FN_DIFF = 3'd6, FN_SUBSET = 3'd7
    } func_t;

    typedef struct packed {
        logic [2:0]         func;
        logic               which_set;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] element;
        logic               found;
        logic [5:0]         count;
        logic               empty_res;
        logic               overflow;
        logic               last;
    } out_item_t;
endpackage
`default_nettype wire

/* sv/tsm_front.sv */
// Intake stage with a two-entry command queue.
// Depends on tsm_pkg.
`default_nettype none
module tsm_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  tsm_pkg::in_item_t      s_data,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output tsm_pkg::in_item_t      q_data
);
    import tsm_pkg::*;

    in_item_t   mem_reg [2];
    logic [1:0] fill_reg, fill_next;
    logic       rd_reg, wr_reg;
    logic       push, pop;

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_data  = mem_reg[rd_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) fill_next = fill_reg + 2'd1;
        else if (pop && !push) fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
            rd_reg   <= 1'b0;
            wr_reg   <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= s_data;
    end
endmodule
`default_nettype wire

/* sv/tsm_back.sv */
// Set stores and operation sequencer; walks slots for set operations.
// Depends on tsm_pkg and the assertion macro header.
`default_nettype none
`include "two_set_membership_engine_top_assert.svh"
module tsm_back #(
    parameter int SET_CAPACITY = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  tsm_pkg::in_item_t      q_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tsm_pkg::out_item_t     m_data
);
    import tsm_pkg::*;

    localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int CW = $clog2(SET_CAPACITY + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001, ST_WALK = 4'b0010, ST_EMIT = 4'b0100, ST_DONE = 4'b1000
    } state_t;

    logic [31:0]       val_reg [2][SET_CAPACITY];
    logic [SET_CAPACITY-1:0] vld_reg [2];
    logic [CW-1:0]     cnt_reg [2];

    state_t            state_reg, state_next;
    in_item_t          cmd_reg;
    logic [IW-1:0]     idx_reg;
    logic              pass_reg;     // union second pass: walk the other set
    logic              any_reg;
    logic              sub_reg;
    logic [31:0]       pend_reg;     // held element awaiting a successor
    logic              pend_vld_reg;
    out_item_t         out_reg;
    logic              out_vld_reg;

    logic              cs, os;
    logic [31:0]       cur;
    logic              cur_vld;
    logic [SET_CAPACITY-1:0] hit_c, hit_o, hit_wc, hit_wo;
    logic              in_c, in_o, w_in_c, w_in_o, full;
    logic [IW-1:0]     free_idx, hit_idx;
    logic              keep, last_slot, out_free;
    logic [5:0]        cnt6;

    assign cs = q_data.which_set;
    assign os = cmd_reg.which_set;

    // parallel compares for single-value ops and for the walking element
    always_comb begin
        free_idx = '0;
        hit_idx  = '0;
        full     = 1'b1;
        for (int i = SET_CAPACITY - 1; i >= 0; i--) begin
            hit_c[i] = vld_reg[cs][i] && (val_reg[cs][i] == q_data.value);
            if (!vld_reg[cs][i]) begin
                free_idx = IW'(i);
                full     = 1'b0;
            end
            if (hit_c[i]) hit_idx = IW'(i);
        end
    end
    assign in_c = |hit_c;
    assign hit_o = '0;
    assign in_o = |hit_o;

    assign cur     = val_reg[os ^ pass_reg][idx_reg];
    assign cur_vld = vld_reg[os ^ pass_reg][idx_reg];
    always_comb begin
        for (int i = 0; i < SET_CAPACITY; i++) begin
            hit_wo[i] = vld_reg[~(os ^ pass_reg)][i] && (val_reg[~(os ^ pass_reg)][i] == cur);
            hit_wc[i] = hit_wo[i];
        end
    end
    assign w_in_o = |hit_wo;
    assign w_in_c = |hit_wc;

    always_comb begin
        unique case (func_t'(cmd_reg.func))
            FN_INTERSECT: keep = cur_vld && w_in_o;
            FN_DIFF:      keep = cur_vld && !w_in_o;
            FN_UNION:     keep = cur_vld && (pass_reg ? !w_in_c : 1'b1);
            default:      keep = 1'b0;
        endcase
    end

    assign last_slot = (idx_reg == IW'(SET_CAPACITY - 1));
    assign out_free  = !out_vld_reg || m_ready;
    assign q_ready   = (state_reg == ST_IDLE) && out_free;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;
    assign cnt6      = 6'(cnt_reg[cmd_reg.which_set]);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid && q_ready && q_data.func >= FN_INTERSECT
                         && q_data.func != FN_SUBSET) state_next = ST_WALK;
                     else if (q_valid && q_ready && q_data.func == FN_SUBSET)
                         state_next = ST_WALK;
            ST_WALK: if (last_slot && !(cmd_reg.func == FN_UNION && !pass_reg)
                         && !(keep && pend_vld_reg && !out_free)) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            ST_EMIT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            out_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            pass_reg     <= 1'b0;
            idx_reg      <= '0;
            any_reg      <= 1'b0;
            sub_reg      <= 1'b1;
            for (int s = 0; s < 2; s++) begin
                vld_reg[s] <= '0;
                cnt_reg[s] <= '0;
            end
        end else begin
            if (m_ready) out_vld_reg <= 1'b0;
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: if (q_valid && q_ready) begin
                    cmd_reg      <= q_data;
                    idx_reg      <= '0;
                    pass_reg     <= 1'b0;
                    any_reg      <= 1'b0;
                    sub_reg      <= 1'b1;
                    pend_vld_reg <= 1'b0;
                    out_reg      <= '{element: '0, found: 1'b0, count: 6'(cnt_reg[cs]),
                                      empty_res: 1'b0, overflow: 1'b0, last: 1'b1};
                    unique case (func_t'(q_data.func))
                        FN_ADD: begin
                            out_vld_reg <= 1'b1;
                            if (!in_c && full) out_reg.overflow <= 1'b1;
                            else if (!in_c) begin
                                vld_reg[cs][free_idx] <= 1'b1;
                                val_reg[cs][free_idx] <= q_data.value;
                                cnt_reg[cs]           <= cnt_reg[cs] + CW'(1);
                                out_reg.count         <= 6'(cnt_reg[cs] + CW'(1));
                            end
                        end
                        FN_REMOVE: begin
                            out_vld_reg <= 1'b1;
                            if (in_c) begin
                                vld_reg[cs][hit_idx] <= 1'b0;
                                val_reg[cs][hit_idx] <= '0;
                                cnt_reg[cs]          <= cnt_reg[cs] - CW'(1);
                                out_reg.count        <= 6'(cnt_reg[cs] - CW'(1));
                            end
                        end
                        FN_CONTAINS: begin
                            out_vld_reg   <= 1'b1;
                            out_reg.found <= in_c || in_o;
                        end
                        FN_SIZE: out_vld_reg <= 1'b1;
                        default: ;
                    endcase
                end
                ST_WALK: begin
                    if (cmd_reg.func == FN_SUBSET) begin
                        if (cur_vld && !w_in_o) sub_reg <= 1'b0;
                        idx_reg <= idx_reg + IW'(1);
                        if (last_slot) idx_reg <= '0;
                    end else if (!(keep && pend_vld_reg && !out_free)) begin
                        if (keep) begin
                            if (pend_vld_reg) begin
                                out_vld_reg <= 1'b1;
                                out_reg <= '{element: pend_reg, found: 1'b0, count: cnt6,
                                             empty_res: 1'b0, overflow: 1'b0, last: 1'b0};
                            end
                            pend_reg     <= cur;
                            pend_vld_reg <= 1'b1;
                            any_reg      <= 1'b1;
                        end
                        idx_reg <= idx_reg + IW'(1);
                        if (last_slot) begin
                            idx_reg  <= '0;
                            pass_reg <= 1'b1;
                        end
                    end
                end
                ST_DONE: if (out_free) begin
                    out_vld_reg <= 1'b1;
                    if (cmd_reg.func == FN_SUBSET)
                        out_reg <= '{element: '0, found: sub_reg, count: cnt6,
                                     empty_res: 1'b0, overflow: 1'b0, last: 1'b1};
                    else if (pend_vld_reg)
                        out_reg <= '{element: pend_reg, found: 1'b0, count: cnt6,
                                     empty_res: 1'b0, overflow: 1'b0, last: 1'b1};
                    else
                        out_reg <= '{element: '0, found: 1'b0, count: cnt6,
                                     empty_res: 1'b1, overflow: 1'b0, last: 1'b1};
                end
                default: ;
            endcase
        end
    end

    `TSM_ASSERT_IMP(a_onehot, aclk, aresetn, 1'b1, $onehot(state_reg))
    `TSM_ASSERT_IMP(a_cnt_a, aclk, aresetn, 1'b1, cnt_reg[0] == CW'($countones(vld_reg[0])))
    `TSM_ASSERT_IMP(a_cnt_b, aclk, aresetn, 1'b1, cnt_reg[1] == CW'($countones(vld_reg[1])))
    `TSM_ASSERT_NXT(a_hold, aclk, aresetn, out_vld_reg && !m_ready, out_vld_reg && $stable(out_reg))
endmodule
`default_nettype wire

/* sv/two_set_membership_engine_top.sv */
// Top level of the two-set membership engine: intake queue and set sequencer.
// Depends on tsm_pkg, tsm_front and tsm_back.
//
//  channel | ports                     | payload
//  --------+---------------------------+-------------------------
//  input   | s_valid, s_ready, s_data  | func, which_set, value
//  result  | m_valid, m_ready, m_data  | element..last
//
// Add, remove, contains and size pass through the queue to the sequencer, which
// compares against every slot at once; the result is registered in the output register
// as the sequencer takes the item, and such items can follow each cycle while results are taken.
// Intersect, union, difference and subset walk the slots in order after intake, and a
// stalled result can hold any walk but subset: every slot of one set (of both for union), then a closing step;
// the sequencer takes no item meanwhile. Reset clears both stores' valid bits and counts at once.
// A stalled result holds in the output register and stalls the sequencer;
// the queue keeps taking items until its two entries are full.
`default_nettype none
module two_set_membership_engine_top #(
    parameter int SET_CAPACITY = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  tsm_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output tsm_pkg::out_item_t  m_data
);
    import tsm_pkg::*;

    logic     q_valid, q_ready;
    in_item_t q_data;

    tsm_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_data
    );

    tsm_back #(.SET_CAPACITY(SET_CAPACITY)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire

/* tb/two_set_membership_engine_top_test.sv */
// Self-checking testbench for the two-set membership engine.
// Drives operation items through the valid/ready input, checks every result against a
// set predictor kept in the testbench. Depends on tsm_pkg and two_set_membership_engine_top.
`default_nettype none
module two_set_membership_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tsm_pkg::*;

    localparam int CAP         = 32;
    localparam int RANDOM_OPS  = 350;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 300;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    two_set_membership_engine_top #(.SET_CAPACITY(CAP)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Predictor state: one slot store per set, index 0 is A and 1 is B.
    logic [31:0] slot_val [2][CAP];
    logic        slot_used[2][CAP];
    logic [5:0]  set_size [2];

    out_item_t pending_results[$];
    int        errors      = 0;
    int        results_seen = 0;
    int        items_sent  = 0;
    int        cycles      = 0;
    int        streamed_ops = 0;
    int        overflows   = 0;
    bit        stimulus_done = 0;
    bit        hold_on = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bit set_holds(int s, logic [31:0] v);
        for (int i = 0; i < CAP; i++)
            if (slot_used[s][i] && slot_val[s][i] == v) return 1;
        return 0;
    endfunction

    function automatic out_item_t make_result(logic [31:0] elem, logic fnd, logic [5:0] cnt,
                                              logic emp, logic ovf, logic lst);
        out_item_t r;
        r.element = elem; r.found = fnd; r.count = cnt;
        r.empty_res = emp; r.overflow = ovf; r.last = lst;
        return r;
    endfunction

    // Apply one operation to the predictor and queue the results it causes.
    task automatic predict_set_op(in_item_t it);
        int        c, o, free_slot, n;
        logic      bit_flag;
        out_item_t stream[$];
        c = it.which_set;
        o = 1 - c;
        bit_flag = 0;
        case (func_t'(it.func))
            FN_ADD: begin
                if (!set_holds(c, it.value)) begin
                    free_slot = -1;
                    for (int i = CAP - 1; i >= 0; i--)
                        if (!slot_used[c][i]) free_slot = i;
                    if (free_slot < 0) begin
                        bit_flag = 1;
                        overflows++;
                    end else begin
                        slot_val[c][free_slot] = it.value;
                        slot_used[c][free_slot] = 1;
                        set_size[c]++;
                    end
                end
                pending_results.push_back(make_result(0, 0, set_size[c], 0, bit_flag, 1));
            end
            FN_REMOVE: begin
                for (int i = 0; i < CAP; i++)
                    if (slot_used[c][i] && slot_val[c][i] == it.value) begin
                        slot_used[c][i] = 0;
                        slot_val[c][i] = 0;
                        if (set_size[c] > 0) set_size[c]--;
                        break;
                    end
                pending_results.push_back(make_result(0, 0, set_size[c], 0, 0, 1));
            end
            FN_CONTAINS:
                pending_results.push_back(
                    make_result(0, set_holds(c, it.value), set_size[c], 0, 0, 1));
            FN_SIZE:
                pending_results.push_back(make_result(0, 0, set_size[c], 0, 0, 1));
            FN_SUBSET: begin
                bit_flag = 1;
                for (int i = 0; i < CAP; i++)
                    if (slot_used[c][i] && !set_holds(o, slot_val[c][i])) bit_flag = 0;
                pending_results.push_back(make_result(0, bit_flag, set_size[c], 0, 0, 1));
            end
            default: begin
                streamed_ops++;
                for (int i = 0; i < CAP; i++) begin
                    if (!slot_used[c][i]) continue;
                    if (it.func == FN_INTERSECT && !set_holds(o, slot_val[c][i])) continue;
                    if (it.func == FN_DIFF && set_holds(o, slot_val[c][i])) continue;
                    stream.push_back(make_result(slot_val[c][i], 0, set_size[c], 0, 0, 0));
                end
                if (it.func == FN_UNION)
                    for (int i = 0; i < CAP; i++)
                        if (slot_used[o][i] && !set_holds(c, slot_val[o][i]))
                            stream.push_back(
                                make_result(slot_val[o][i], 0, set_size[c], 0, 0, 0));
                n = stream.size();
                if (n == 0)
                    stream.push_back(make_result(0, 0, set_size[c], 1, 0, 1));
                else
                    stream[n - 1].last = 1;
                foreach (stream[k]) pending_results.push_back(stream[k]);
            end
        endcase
    endtask

    // Result side: random stalls, plus one long hold-off while the sender keeps going.
    initial begin
        int gap;
        m_ready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
            repeat (gap) begin
                m_ready <= 0;
                @(posedge aclk);
            end
            if (hold_on) begin
                m_ready <= 0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_on = 0;
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // Checker: compare each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $realtime, m_data);
            end else begin
                out_item_t want;
                want = pending_results.pop_front();
                if (m_data.element !== want.element || m_data.found !== want.found ||
                    m_data.count !== want.count || m_data.empty_res !== want.empty_res ||
                    m_data.overflow !== want.overflow || m_data.last !== want.last) begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, m_data);
                end
            end
        end
    end

    // Offer one item and wait for acceptance; prediction happens at the accepting edge.
    task automatic send_item(in_item_t it);
        int gap;
        gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 6) : 0;
        repeat (gap) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_set_op(it);
        items_sent++;
    endtask

    function automatic in_item_t op_item(func_t f, logic ws, logic [31:0] v);
        in_item_t it;
        it.func = f; it.which_set = ws; it.value = v;
        return it;
    endfunction

    // Values mostly from a small pool so that sets overlap and duplicates happen.
    function automatic logic [31:0] pool_value();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFC + $urandom_range(0, 3);
            2: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    typedef struct {
        func_t       f;
        logic        ws;
        logic [31:0] v;
        bit          typed;     // expected result given in the row
        out_item_t   want;
    } step_row_t;

    step_row_t directed_rows[$];

    initial begin
        in_item_t  it;
        int        r;
        s_valid = 0;
        s_data  = '0;
        aresetn = 0;
        for (int s = 0; s < 2; s++) begin
            set_size[s] = 0;
            for (int i = 0; i < CAP; i++) begin
                slot_val[s][i] = 0;
                slot_used[s][i] = 0;
            end
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed rows: after reset, extremes, every operation and empty results.
        directed_rows = '{
            '{FN_SIZE,      0, 0,            1, make_result(0, 0, 0, 0, 0, 1)},
            '{FN_SUBSET,    1, 0,            1, make_result(0, 1, 0, 0, 0, 1)},
            '{FN_INTERSECT, 0, 0,            1, make_result(0, 0, 0, 1, 0, 1)},
            '{FN_UNION,     1, 0,            1, make_result(0, 0, 0, 1, 0, 1)},
            '{FN_REMOVE,    0, 5,            1, make_result(0, 0, 0, 0, 0, 1)},
            '{FN_ADD,       0, 32'h8000_0000, 1, make_result(0, 0, 1, 0, 0, 1)},
            '{FN_ADD,       0, 32'h7FFF_FFFF, 1, make_result(0, 0, 2, 0, 0, 1)},
            '{FN_ADD,       0, 32'hFFFF_FFFF, 1, make_result(0, 0, 3, 0, 0, 1)},
            '{FN_ADD,       0, 32'h7FFF_FFFF, 1, make_result(0, 0, 3, 0, 0, 1)},
            '{FN_ADD,       1, 32'hFFFF_FFFF, 1, make_result(0, 0, 1, 0, 0, 1)},
            '{FN_ADD,       1, 0,            1, make_result(0, 0, 2, 0, 0, 1)},
            '{FN_CONTAINS,  0, 32'h8000_0000, 1, make_result(0, 1, 3, 0, 0, 1)},
            '{FN_CONTAINS,  1, 32'h8000_0000, 1, make_result(0, 0, 2, 0, 0, 1)},
            '{FN_INTERSECT, 0, 0,            0, '0},
            '{FN_UNION,     0, 0,            0, '0},
            '{FN_UNION,     1, 0,            0, '0},
            '{FN_DIFF,      0, 0,            0, '0},
            '{FN_DIFF,      1, 0,            0, '0},
            '{FN_SUBSET,    0, 0,            1, make_result(0, 0, 3, 0, 0, 1)},
            '{FN_SUBSET,    1, 0,            0, '0},
            '{FN_REMOVE,    0, 32'h7FFF_FFFF, 1, make_result(0, 0, 2, 0, 0, 1)},
            '{FN_REMOVE,    0, 32'h7FFF_FFFF, 1, make_result(0, 0, 2, 0, 0, 1)},
            '{FN_ADD,       0, 32'h1234_5678, 1, make_result(0, 0, 3, 0, 0, 1)}
        };
        foreach (directed_rows[k]) begin
            it = op_item(directed_rows[k].f, directed_rows[k].ws, directed_rows[k].v);
            // A typed row must agree with the predictor's own result too.
            send_item(it);
            if (directed_rows[k].typed &&
                pending_results[pending_results.size() - 1] !== directed_rows[k].want) begin
                errors++;
                $display("%0t: row %0d expected %p actual %p", $realtime, k,
                         directed_rows[k].want, pending_results[pending_results.size() - 1]);
            end
        end

        // Fill set B past capacity to hit overflow, while the receiver holds off.
        hold_on = 1;
        for (int i = 0; i < CAP + 2; i++)
            send_item(op_item(FN_ADD, 1, 32'h4000_0000 + i));
        send_item(op_item(FN_UNION, 1, 0));
        send_item(op_item(FN_SUBSET, 0, 0));

        // Random part: mostly add/remove churn with random queries mixed in.
        for (int k = 0; k < RANDOM_OPS; k++) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                it = op_item(FN_ADD, 1'($urandom_range(0, 1)), pool_value());
            else if (r < 6)
                it = op_item(FN_REMOVE, 1'($urandom_range(0, 1)), pool_value());
            else if (r == 6)
                it = op_item(func_t'($urandom_range(2, 3)), 1'($urandom_range(0, 1)),
                             pool_value());
            else
                it = op_item(func_t'($urandom_range(4, 7)), 1'($urandom_range(0, 1)),
                             $urandom);
            send_item(it);
        end
        s_valid <= 0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Sent %0d items, checked %0d results (%0d streamed set ops, %0d overflows).",
                 items_sent, results_seen, streamed_ops, overflows);
        if (errors == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/tsm_pkg.sv
sv/tsm_front.sv
sv/tsm_back.sv
sv/two_set_membership_engine_top.sv
tb/two_set_membership_engine_top_test.sv
